FILE: hdl/bc1_pkg.sv
// Shared types, constants and colour arithmetic for the BC1 block decoder.
// No dependencies; every other file in hdl/ refers to this package by scoped name.
package bc1_pkg;

    localparam int COLOR_W    = 16;
    localparam int CODE_W     = 32;
    localparam int MIP_W      = 4;
    localparam int IDX_W      = 16;
    localparam int PIX_COORD_W = 10;
    localparam int PIX_CNT_W  = 4;

    localparam logic [PIX_CNT_W-1:0] PIX_LAST = 4'hF;

    // Reciprocal for a truncating divide by three of sums up to 189.
    localparam logic [16:0] DIV3_MUL   = 17'd171;
    localparam int          DIV3_SHIFT = 9;

    typedef logic [COLOR_W-1:0]    t_color;
    typedef logic [3:0][COLOR_W-1:0] t_palette;
    typedef logic [15:0][1:0]      t_codes;

    function automatic logic [6:0] div3(input logic [7:0] s);
        logic [16:0] p;
        p = 17'(s) * DIV3_MUL;
        return 7'(p >> DIV3_SHIFT);
    endfunction

    // (2a + b) / 3 on each 565 field.
    function automatic t_color third565(input t_color a, input t_color b);
        logic [7:0] sr, sg, sb;
        logic [6:0] qr, qg, qb;
        sr = {2'b00, a[15:11], 1'b0} + {3'b000, b[15:11]};
        sg = {1'b0, a[10:5], 1'b0} + {2'b00, b[10:5]};
        sb = {2'b00, a[4:0], 1'b0} + {3'b000, b[4:0]};
        qr = div3(sr);
        qg = div3(sg);
        qb = div3(sb);
        return {qr[4:0], qg[5:0], qb[4:0]};
    endfunction

    // (a + b) / 2 on each 565 field.
    function automatic t_color half565(input t_color a, input t_color b);
        logic [5:0] sr, sb;
        logic [6:0] sg;
        sr = {1'b0, a[15:11]} + {1'b0, b[15:11]};
        sg = {1'b0, a[10:5]} + {1'b0, b[10:5]};
        sb = {1'b0, a[4:0]} + {1'b0, b[4:0]};
        return {sr[5:1], sg[6:1], sb[5:1]};
    endfunction

    function automatic t_palette make_palette(input t_color c0, input t_color c1);
        t_palette p;
        p[0] = c0;
        p[1] = c1;
        if (c0 > c1) begin
            p[2] = third565(c0, c1);
            p[3] = third565(c1, c0);
        end else begin
            p[2] = half565(c0, c1);
            p[3] = '0;
        end
        return p;
    endfunction

endpackage

FILE: hdl/bc1_if.sv
// Valid/ready channel interfaces for compressed blocks in and decoded pixels out.
// Depends on bc1_pkg for field widths.
interface bc1_blk_if;
    logic                             valid;
    logic                             ready;
    logic [bc1_pkg::COLOR_W-1:0]      first_color;
    logic [bc1_pkg::COLOR_W-1:0]      second_color;
    logic [bc1_pkg::CODE_W-1:0]       code_word;

    modport source (output valid, first_color, second_color, code_word, input ready);
    modport sink   (input valid, first_color, second_color, code_word, output ready);
endinterface

interface bc1_pix_if;
    logic                             valid;
    logic                             ready;
    logic [bc1_pkg::COLOR_W-1:0]      pixel_color;
    logic [bc1_pkg::PIX_COORD_W-1:0]  pixel_x;
    logic [bc1_pkg::PIX_COORD_W-1:0]  pixel_y;
    logic                             inside_image;
    logic                             last_of_block;

    modport source (output valid, pixel_color, pixel_x, pixel_y, inside_image, last_of_block,
                    input ready);
    modport sink   (input valid, pixel_color, pixel_x, pixel_y, inside_image, last_of_block,
                    output ready);
endinterface

FILE: hdl/bc1_pos.sv
// Mip level register, block counter and block position within the mip image.
// Recomputes image size and the block's column/row (bit-serial divide) after reset
// or a mip write. Depends on bc1_pkg.
module bc1_pos #(
    parameter int  BASE_SIDE = 1024,
    localparam int SIDE_W    = $clog2(BASE_SIDE + 1),
    localparam int PR_MAX    = (BASE_SIDE + 3) / 4,
    localparam int PR_W      = $clog2(PR_MAX + 1),
    localparam int BC_W      = (PR_MAX > 1) ? $clog2(PR_MAX) : 1,
    localparam int NB_W      = 2 * PR_W
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [bc1_pkg::MIP_W-1:0]   i_cfg_data,
    input  logic                        i_advance,
    output logic                        o_ready,
    output logic [BC_W-1:0]             o_blk_x,
    output logic [BC_W-1:0]             o_blk_y,
    output logic [SIDE_W-1:0]           o_side
);

    localparam logic [2:0] ST_SIZE = 3'd0;
    localparam logic [2:0] ST_AREA = 3'd1;
    localparam logic [2:0] ST_DIV  = 3'd2;
    localparam logic [2:0] ST_FIX  = 3'd3;
    localparam logic [2:0] ST_IDLE = 3'd4;

    logic [2:0]                     r_state, n_state;
    logic [bc1_pkg::MIP_W-1:0]      r_mip, n_mip;
    logic [bc1_pkg::IDX_W-1:0]      r_idx, n_idx;
    logic                           r_stale, n_stale;
    logic [BC_W-1:0]                r_bx, n_bx, r_by, n_by;
    logic [SIDE_W-1:0]              r_side, n_side;
    logic [PR_W-1:0]                r_per_row, n_per_row;
    logic [NB_W-1:0]                r_nblk, n_nblk;
    logic [PR_W-1:0]                r_rem, n_rem;
    logic [bc1_pkg::IDX_W-1:0]      r_quo, n_quo;
    logic [3:0]                     r_cnt, n_cnt;

    logic [SIDE_W-1:0]              side_raw;
    logic [SIDE_W:0]                side_sum;
    logic [PR_W:0]                  trial;
    logic                           ge;
    logic [bc1_pkg::IDX_W-1:0]      idx_eff;
    logic [bc1_pkg::IDX_W:0]        idx_inc;
    logic [BC_W:0]                  bx_inc;
    logic                           wrap;
    logic                           row_end;

    always_comb begin
        side_raw = SIDE_W'(BASE_SIDE >> r_mip);
        if (side_raw == '0) begin
            side_raw = SIDE_W'(1);
        end
        side_sum = {1'b0, side_raw} + (SIDE_W + 1)'(3);
        trial    = {r_rem, r_idx[~r_cnt]};
        ge       = (trial >= {1'b0, r_per_row});
        // a stale counter advances as if it stood at block zero
        idx_eff  = r_stale ? '0 : r_idx;
        idx_inc  = {1'b0, idx_eff} + (bc1_pkg::IDX_W + 1)'(1);
        bx_inc   = {1'b0, r_bx} + (BC_W + 1)'(1);
        wrap     = idx_inc[bc1_pkg::IDX_W] || (32'(idx_inc) >= 32'(r_nblk));
        row_end  = (32'(bx_inc) == 32'(r_per_row));
    end

    always_comb begin
        n_state   = r_state;
        n_mip     = r_mip;
        n_idx     = r_idx;
        n_stale   = r_stale;
        n_bx      = r_bx;
        n_by      = r_by;
        n_side    = r_side;
        n_per_row = r_per_row;
        n_nblk    = r_nblk;
        n_rem     = r_rem;
        n_quo     = r_quo;
        n_cnt     = r_cnt;
        case (r_state)
            ST_SIZE: begin
                n_side    = side_raw;
                n_per_row = PR_W'(side_sum >> 2);
                n_state   = ST_AREA;
            end
            ST_AREA: begin
                n_nblk  = NB_W'(r_per_row * r_per_row);
                n_rem   = '0;
                n_quo   = '0;
                n_cnt   = '0;
                n_state = ST_DIV;
            end
            ST_DIV: begin
                // one quotient bit per cycle, most significant first
                n_rem = ge ? PR_W'(trial - {1'b0, r_per_row}) : PR_W'(trial);
                n_quo = {r_quo[bc1_pkg::IDX_W-2:0], ge};
                n_cnt = r_cnt + 4'd1;
                if (r_cnt == 4'hF) begin
                    n_state = ST_FIX;
                end
            end
            ST_FIX: begin
                // a counter left beyond the new image decodes as block zero; hold its value
                if (32'(r_idx) >= 32'(r_nblk)) begin
                    n_stale = 1'b1;
                    n_bx    = '0;
                    n_by    = '0;
                end else begin
                    n_stale = 1'b0;
                    n_bx    = BC_W'(r_rem);
                    n_by    = BC_W'(r_quo);
                end
                n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_advance) begin
                    n_stale = 1'b0;
                    if (wrap) begin
                        n_idx = '0;
                        n_bx  = '0;
                        n_by  = '0;
                    end else begin
                        n_idx = idx_inc[bc1_pkg::IDX_W-1:0];
                        if (row_end) begin
                            n_bx = '0;
                            n_by = r_by + BC_W'(1);
                        end else begin
                            n_bx = bx_inc[BC_W-1:0];
                        end
                    end
                end
            end
            default: begin
                n_state = ST_SIZE;
            end
        endcase
        if (i_cfg_valid) begin
            n_mip   = i_cfg_data;
            n_state = ST_SIZE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_SIZE;
            r_mip   <= '0;
            r_idx   <= '0;
            r_stale <= 1'b0;
            r_bx    <= '0;
            r_by    <= '0;
        end else begin
            r_state <= n_state;
            r_mip   <= n_mip;
            r_idx   <= n_idx;
            r_stale <= n_stale;
            r_bx    <= n_bx;
            r_by    <= n_by;
        end
    end

    always_ff @(posedge i_clk) begin
        r_side    <= n_side;
        r_per_row <= n_per_row;
        r_nblk    <= n_nblk;
        r_rem     <= n_rem;
        r_quo     <= n_quo;
        r_cnt     <= n_cnt;
    end

    assign o_cfg_ready = 1'b1;
    assign o_ready     = (r_state == ST_IDLE);
    assign o_blk_x     = r_bx;
    assign o_blk_y     = r_by;
    assign o_side      = r_side;

endmodule

FILE: hdl/bc1_pal.sv
// Input register for one compressed block plus its palette expansion.
// Depends on bc1_pkg and bc1_blk_if.
module bc1_pal #(
    parameter int  BASE_SIDE = 1024,
    localparam int PR_MAX    = (BASE_SIDE + 3) / 4,
    localparam int BC_W      = (PR_MAX > 1) ? $clog2(PR_MAX) : 1,
    localparam int CO_W      = BC_W + 2
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    bc1_blk_if.sink             i_blk,
    input  logic                i_pos_ready,
    input  logic [BC_W-1:0]     i_blk_x,
    input  logic [BC_W-1:0]     i_blk_y,
    input  logic                i_take,
    output logic                o_advance,
    output logic                o_valid,
    output bc1_pkg::t_palette   o_palette,
    output bc1_pkg::t_codes     o_codes,
    output logic [CO_W-1:0]     o_base_x,
    output logic [CO_W-1:0]     o_base_y
);

    logic               r_v;
    bc1_pkg::t_color    r_c0, r_c1;
    bc1_pkg::t_codes    r_codes;
    logic [CO_W-1:0]    r_bx, r_by;
    logic               accept;

    assign i_blk.ready = i_pos_ready && (!r_v || i_take);
    assign accept      = i_blk.valid && i_blk.ready;
    assign o_advance   = accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (accept) begin
            r_v <= 1'b1;
        end else if (i_take) begin
            r_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_c0    <= i_blk.first_color;
            r_c1    <= i_blk.second_color;
            r_codes <= i_blk.code_word;
            r_bx    <= {i_blk_x, 2'b00};
            r_by    <= {i_blk_y, 2'b00};
        end
    end

    assign o_valid   = r_v;
    assign o_palette = bc1_pkg::make_palette(r_c0, r_c1);
    assign o_codes   = r_codes;
    assign o_base_x  = r_bx;
    assign o_base_y  = r_by;

endmodule

FILE: hdl/bc1_emit.sv
// Pixel emitter: holds one expanded block and sends its sixteen pixels, one per beat,
// through an output register. Depends on bc1_pkg and bc1_pix_if.
module bc1_emit #(
    parameter int  BASE_SIDE = 1024,
    localparam int SIDE_W    = $clog2(BASE_SIDE + 1),
    localparam int PR_MAX    = (BASE_SIDE + 3) / 4,
    localparam int BC_W      = (PR_MAX > 1) ? $clog2(PR_MAX) : 1,
    localparam int CO_W      = BC_W + 2
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  bc1_pkg::t_palette   i_palette,
    input  bc1_pkg::t_codes     i_codes,
    input  logic [CO_W-1:0]     i_base_x,
    input  logic [CO_W-1:0]     i_base_y,
    input  logic [SIDE_W-1:0]   i_side,
    output logic                o_take,
    bc1_pix_if.source           o_pix
);

    logic                               r_ev;
    logic [bc1_pkg::PIX_CNT_W-1:0]      r_k;
    bc1_pkg::t_palette                  r_pal;
    bc1_pkg::t_codes                    r_codes;
    logic [CO_W-1:0]                    r_bx, r_by;

    logic                               r_ov;
    bc1_pkg::t_color                    r_color;
    logic [bc1_pkg::PIX_COORD_W-1:0]    r_x, r_y;
    logic                               r_inside, r_last;

    logic                               out_load;
    logic                               last;
    logic [CO_W-1:0]                    x, y;
    logic [31:0]                        x_ext, y_ext;

    assign out_load = r_ev && (!r_ov || o_pix.ready);
    assign last     = (r_k == bc1_pkg::PIX_LAST);
    assign o_take   = !r_ev || (out_load && last);

    assign x     = r_bx + CO_W'(r_k[1:0]);
    assign y     = r_by + CO_W'(r_k[3:2]);
    assign x_ext = 32'(x);
    assign y_ext = 32'(y);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ev <= 1'b0;
            r_k  <= '0;
            r_ov <= 1'b0;
        end else begin
            if (o_take) begin
                r_ev <= i_valid;
                r_k  <= '0;
            end else if (out_load) begin
                r_k <= r_k + bc1_pkg::PIX_CNT_W'(1);
            end
            if (out_load) begin
                r_ov <= 1'b1;
            end else if (o_pix.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && i_valid) begin
            r_pal   <= i_palette;
            r_codes <= i_codes;
            r_bx    <= i_base_x;
            r_by    <= i_base_y;
        end
        if (out_load) begin
            r_color  <= r_pal[r_codes[r_k]];
            r_x      <= x_ext[bc1_pkg::PIX_COORD_W-1:0];
            r_y      <= y_ext[bc1_pkg::PIX_COORD_W-1:0];
            r_inside <= (x_ext < 32'(i_side)) && (y_ext < 32'(i_side));
            r_last   <= last;
        end
    end

    assign o_pix.valid         = r_ov;
    assign o_pix.pixel_color   = r_color;
    assign o_pix.pixel_x       = r_x;
    assign o_pix.pixel_y       = r_y;
    assign o_pix.inside_image  = r_inside;
    assign o_pix.last_of_block = r_last;

endmodule

FILE: hdl/bc1_block_decoder_rgb565.sv
// BC1 block decoder, RGB565 out: one 64-bit block in, sixteen pixels out in row-major order.
// A block passes the palette input register, the block register and the output register;
// its pixels leave one per cycle while o_pix is not stalled; a new block can be taken while
// the last is emitted. Reset (synchronous, active low) clears the mip level and block counter,
// then the position unit sizes the image before taking blocks; a mip write does the same.
module bc1_block_decoder_rgb565 #(
    parameter int BASE_SIDE = 1024
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [bc1_pkg::MIP_W-1:0]   i_cfg_data,
    bc1_blk_if.sink                     i_blk,
    bc1_pix_if.source                   o_pix
);

    localparam int SIDE_W = $clog2(BASE_SIDE + 1);
    localparam int PR_MAX = (BASE_SIDE + 3) / 4;
    localparam int BC_W   = (PR_MAX > 1) ? $clog2(PR_MAX) : 1;
    localparam int CO_W   = BC_W + 2;

    logic                   pos_ready;
    logic                   advance;
    logic [BC_W-1:0]        blk_x, blk_y;
    logic [SIDE_W-1:0]      side;
    logic                   pal_valid;
    logic                   take;
    bc1_pkg::t_palette      palette;
    bc1_pkg::t_codes        codes;
    logic [CO_W-1:0]        base_x, base_y;

    bc1_pos #(.BASE_SIDE(BASE_SIDE)) u_pos (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_advance   (advance),
        .o_ready     (pos_ready),
        .o_blk_x     (blk_x),
        .o_blk_y     (blk_y),
        .o_side      (side)
    );

    bc1_pal #(.BASE_SIDE(BASE_SIDE)) u_pal (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_blk       (i_blk),
        .i_pos_ready (pos_ready),
        .i_blk_x     (blk_x),
        .i_blk_y     (blk_y),
        .i_take      (take),
        .o_advance   (advance),
        .o_valid     (pal_valid),
        .o_palette   (palette),
        .o_codes     (codes),
        .o_base_x    (base_x),
        .o_base_y    (base_y)
    );

    bc1_emit #(.BASE_SIDE(BASE_SIDE)) u_emit (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (pal_valid),
        .i_palette (palette),
        .i_codes   (codes),
        .i_base_x  (base_x),
        .i_base_y  (base_y),
        .i_side    (side),
        .o_take    (take),
        .o_pix     (o_pix)
    );

endmodule
